>>> hdl/cbmw_pkg.sv
// Shared types and constants for the cartridge bank mapper with work RAM.
`default_nettype none

package cbmw_pkg;

    localparam int WORK_RAM_DEPTH = 256;
    localparam int WRAM_AW        = $clog2(WORK_RAM_DEPTH);

    typedef enum logic [1:0] {
        KIND_CPU_WRITE = 2'd0,
        KIND_CPU_READ  = 2'd1,
        KIND_PPU_FETCH = 2'd2,
        KIND_UNUSED    = 2'd3
    } t_kind;

    localparam logic [11:0] REG_PAGE_HI  = 12'h7EF;
    localparam logic [3:0]  CHR_REG_LAST = 4'h5;
    localparam logic [3:0]  MIRROR_REG   = 4'h6;
    localparam logic [3:0]  PRG_REG_BASE = 4'hA;
    localparam logic [7:0]  WRAM_PAGE_HI = 8'h7F;
    localparam logic [7:0]  FIXED_BANK   = 8'hFF;
    localparam logic [1:0]  FIXED_WINDOW = 2'd3;

    localparam logic [0:0]  REG_BOARD_VARIANT = 1'b0;

    typedef struct packed {
        logic [7:0] bank_number;
        logic       bank_valid;
        logic       nametable_page;
        logic       page_valid;
    } t_map_res;

endpackage

`default_nettype wire

>>> hdl/cbmw_regs.sv
// Bank and mirroring registers with the PRG, CHR and nametable lookup.
`default_nettype none

module cbmw_regs (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_accept,
    input  wire cbmw_pkg::t_kind     i_kind,
    input  wire logic [15:0]         i_address,
    input  wire logic [7:0]          i_write_data,
    input  wire logic                i_variant,
    output cbmw_pkg::t_map_res       o_res
);

    logic [7:0] r_chr [6];
    logic [7:0] r_prg [3];
    logic       r_mirror;

    logic       reg_page;
    logic [3:0] nib;
    logic [3:0] prg_off;
    logic [2:0] slot;
    logic [2:0] hi_idx;
    logic [1:0] tbl;
    logic [1:0] win;

    assign reg_page = i_accept && (i_kind == cbmw_pkg::KIND_CPU_WRITE)
                      && (i_address[15:4] == cbmw_pkg::REG_PAGE_HI);
    assign nib      = i_address[3:0];
    assign prg_off  = nib - cbmw_pkg::PRG_REG_BASE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 6; k++) r_chr[k] <= '0;
            for (int k = 0; k < 3; k++) r_prg[k] <= '0;
            r_mirror <= 1'b0;
        end else if (reg_page) begin
            if (nib <= cbmw_pkg::CHR_REG_LAST) begin
                r_chr[nib[2:0]] <= i_write_data;
            end else if (nib == cbmw_pkg::MIRROR_REG) begin
                r_mirror <= i_write_data[0];
            end else if (nib >= cbmw_pkg::PRG_REG_BASE) begin
                r_prg[prg_off[2:1]] <= i_write_data;
            end
        end
    end

    assign slot   = i_address[12:10];
    assign hi_idx = {1'b0, slot[1:0]} + 3'd2;
    assign tbl    = i_address[11:10];
    assign win    = i_address[14:13];

    always_comb begin
        o_res = '0;
        unique case (i_kind)
            cbmw_pkg::KIND_CPU_READ: begin
                if (i_address[15]) begin
                    o_res.bank_valid  = 1'b1;
                    o_res.bank_number = (win == cbmw_pkg::FIXED_WINDOW) ?
                                        cbmw_pkg::FIXED_BANK : r_prg[win];
                end
            end
            cbmw_pkg::KIND_PPU_FETCH: begin
                if (!i_address[13]) begin
                    o_res.bank_valid  = 1'b1;
                    o_res.bank_number = slot[2] ? r_chr[hi_idx] :
                                        {r_chr[{2'b00, slot[1]}][7:1], slot[0]};
                end else begin
                    o_res.page_valid = 1'b1;
                    if (i_variant) begin
                        o_res.nametable_page = r_chr[{2'b00, tbl[1]}][7];
                    end else begin
                        o_res.nametable_page = r_mirror ? tbl[0] : tbl[1];
                    end
                end
            end
            default: begin
                o_res = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> hdl/cartridge_bank_mapper_with_wram_core.sv
// Top level of the cartridge bank mapper with 256-byte work RAM.
// One bus access per clock unless the output stalls: a request is taken in every
// cycle that o_ready is high, and its result passes through the read stage into the
// output register. The work RAM is a single-port synchronous array read and written
// at the accepting edge; per-entry valid flops cleared by reset make unwritten bytes
// read as zero, so there is no clearing pass. Bank and mirroring lookups are resolved
// at acceptance and travel with the request. board_variant is at APB byte address 0.
`default_nettype none

module cartridge_bank_mapper_with_wram_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output      logic        o_ready,
    input  wire logic [1:0]  i_kind,
    input  wire logic [15:0] i_address,
    input  wire logic [7:0]  i_write_data,
    output      logic        o_valid,
    input  wire logic        i_ready,
    output      logic [7:0]  o_read_data,
    output      logic        o_read_served,
    output      logic [7:0]  o_bank_number,
    output      logic        o_bank_valid,
    output      logic        o_nametable_page,
    output      logic        o_page_valid,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output      logic [31:0] prdata,
    output      logic        pready
);

    cbmw_pkg::t_kind     kind;
    cbmw_pkg::t_map_res  map_res;

    logic                         r_variant;
    logic [7:0]                   wram [cbmw_pkg::WORK_RAM_DEPTH];
    logic [cbmw_pkg::WORK_RAM_DEPTH-1:0] r_wvld;
    logic [7:0]                   r_mem_q;

    logic                         r_s1_vld;
    logic                         r_s1_served;
    logic                         r_s1_wvld;
    cbmw_pkg::t_map_res           r_s1_map;

    logic                         r_out_vld;
    logic [7:0]                   r_out_data;
    logic                         r_out_served;
    cbmw_pkg::t_map_res           r_out_map;

    logic                         accept;
    logic                         s1_move;
    logic                         wram_hit;
    logic                         wram_wr;
    logic                         wram_rd;
    logic [cbmw_pkg::WRAM_AW-1:0] wa;
    logic                         cfg_wr;

    assign kind     = cbmw_pkg::t_kind'(i_kind);
    assign s1_move  = r_s1_vld && (!r_out_vld || i_ready);
    assign o_ready  = !r_s1_vld || s1_move;
    assign accept   = i_valid && o_ready;
    assign wa       = i_address[cbmw_pkg::WRAM_AW-1:0];
    assign wram_hit = (i_address[15:8] == cbmw_pkg::WRAM_PAGE_HI) && !r_variant;
    assign wram_wr  = accept && wram_hit && (kind == cbmw_pkg::KIND_CPU_WRITE);
    assign wram_rd  = wram_hit && (kind == cbmw_pkg::KIND_CPU_READ);

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[2] == cbmw_pkg::REG_BOARD_VARIANT);
    assign prdata = (paddr[2] == cbmw_pkg::REG_BOARD_VARIANT) ?
                    {31'd0, r_variant} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_variant <= 1'b0;
        end else if (cfg_wr) begin
            r_variant <= pwdata[0];
        end
    end

    cbmw_regs u_regs (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_kind       (kind),
        .i_address    (i_address),
        .i_write_data (i_write_data),
        .i_variant    (r_variant),
        .o_res        (map_res)
    );

    // work RAM
    always_ff @(posedge i_clk) begin
        if (wram_wr) begin
            wram[wa] <= i_write_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mem_q <= wram[wa];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wvld <= '0;
        end else if (wram_wr) begin
            r_wvld[wa] <= 1'b1;
        end
    end

    // read stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (accept) begin
            r_s1_vld <= 1'b1;
        end else if (s1_move) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_served <= wram_rd;
            r_s1_wvld   <= r_wvld[wa];
            r_s1_map    <= map_res;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_move) begin
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_served <= r_s1_served;
            r_out_data   <= (r_s1_served && r_s1_wvld) ? r_mem_q : 8'd0;
            r_out_map    <= r_s1_map;
        end
    end

    assign o_valid          = r_out_vld;
    assign o_read_data      = r_out_data;
    assign o_read_served    = r_out_served;
    assign o_bank_number    = r_out_map.bank_number;
    assign o_bank_valid     = r_out_map.bank_valid;
    assign o_nametable_page = r_out_map.nametable_page;
    assign o_page_valid     = r_out_map.page_valid;

    a_one_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($countones({o_read_served, o_bank_valid, o_page_valid}) <= 1))
        else $error("more than one result source");

    a_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_read_served) |-> (o_read_data == 8'd0))
        else $error("read data without work RAM hit");

    a_page_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_page_valid) |-> !o_nametable_page)
        else $error("nametable page without page valid");

    a_mem_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && r_s1_wvld && !s1_move) |=> $stable(r_mem_q))
        else $error("work RAM data lost under stall");

endmodule

`default_nettype wire

>>> tb/tb_cartridge_bank_mapper_with_wram_core.sv
// Self-checking testbench for the cartridge bank mapper core with work RAM.
`timescale 1ns / 1ps

module tb_cartridge_bank_mapper_with_wram_core;

    localparam int CLK_PERIOD     = 4;
    localparam int RESET_CYCLES   = 5;
    localparam int NUM_PHASES     = 8;
    localparam int PHASE_ITEMS    = 213;
    localparam int DRAIN_CYCLES   = 8;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int PCT_HEAVY      = 83;
    localparam int PCT_LIGHT      = 10;

    localparam logic [2:0] ADDR_BOARD_VARIANT = {cbmw_pkg::REG_BOARD_VARIANT, 2'b00};
    localparam logic [2:0] ADDR_NO_REG        = 3'd4;

    typedef struct packed {
        logic [7:0] read_data;
        logic       read_served;
        logic [7:0] bank_number;
        logic       bank_valid;
        logic       nametable_page;
        logic       page_valid;
    } t_access_res;

    typedef struct {
        cbmw_pkg::t_kind kind;
        logic [15:0]     addr;
        logic [7:0]      data;
        bit              typed;
        t_access_res     want;
    } t_stim_row;

    localparam t_access_res RES_ALL_ZERO = '0;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_valid      = 1'b0;
    logic [1:0]  i_kind       = cbmw_pkg::KIND_CPU_WRITE;
    logic [15:0] i_address    = '0;
    logic [7:0]  i_write_data = '0;
    logic        i_ready      = 1'b0;
    logic        psel         = 1'b0;
    logic        penable      = 1'b0;
    logic        pwrite       = 1'b0;
    logic [2:0]  paddr        = '0;
    logic [31:0] pwdata       = '0;

    logic        o_ready;
    logic        o_valid;
    logic [7:0]  o_read_data;
    logic        o_read_served;
    logic [7:0]  o_bank_number;
    logic        o_bank_valid;
    logic        o_nametable_page;
    logic        o_page_valid;
    logic [31:0] prdata;
    logic        pready;

    cartridge_bank_mapper_with_wram_core uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_kind           (i_kind),
        .i_address        (i_address),
        .i_write_data     (i_write_data),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_read_data      (o_read_data),
        .o_read_served    (o_read_served),
        .o_bank_number    (o_bank_number),
        .o_bank_valid     (o_bank_valid),
        .o_nametable_page (o_nametable_page),
        .o_page_valid     (o_page_valid),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    // mapper state mirror
    logic [7:0] prg_bank [3];
    logic [7:0] chr_bank [6];
    logic       mirror_vertical;
    logic [7:0] wram_mirror [cbmw_pkg::WORK_RAM_DEPTH];
    logic       board_variant_q;

    t_access_res pending_results [$];
    t_stim_row   directed_rows [$];
    int          error_count   = 0;
    int unsigned cycle_count   = 0;
    int          send_idle_pct = 0;
    int          ready_stall_pct = 0;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= ready_stall_pct);
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    // applies one bus access to the mirrored state and returns its answer
    function automatic t_access_res map_access(cbmw_pkg::t_kind kind, logic [15:0] addr,
                                               logic [7:0] wdata);
        t_access_res r;
        logic [13:0] pa;
        logic [2:0]  slot;
        logic [1:0]  tbl;
        logic [1:0]  win;
        logic [3:0]  prg_off;
        r = '0;
        prg_off = addr[3:0] - cbmw_pkg::PRG_REG_BASE;
        case (kind)
            cbmw_pkg::KIND_CPU_WRITE: begin
                if (addr[15:4] == cbmw_pkg::REG_PAGE_HI
                    && addr[3:0] <= cbmw_pkg::CHR_REG_LAST) begin
                    chr_bank[addr[2:0]] = wdata;
                end else if (addr[15:4] == cbmw_pkg::REG_PAGE_HI
                             && addr[3:0] == cbmw_pkg::MIRROR_REG) begin
                    mirror_vertical = wdata[0];
                end else if (addr[15:4] == cbmw_pkg::REG_PAGE_HI
                             && addr[3:0] >= cbmw_pkg::PRG_REG_BASE) begin
                    prg_bank[prg_off[2:1]] = wdata;
                end else if (addr[15:8] == cbmw_pkg::WRAM_PAGE_HI && !board_variant_q) begin
                    wram_mirror[addr[7:0]] = wdata;
                end
            end
            cbmw_pkg::KIND_CPU_READ: begin
                if (addr[15:8] == cbmw_pkg::WRAM_PAGE_HI && !board_variant_q) begin
                    r.read_data   = wram_mirror[addr[7:0]];
                    r.read_served = 1'b1;
                end else if (addr[15]) begin
                    win = addr[14:13];
                    r.bank_number = (win == cbmw_pkg::FIXED_WINDOW) ?
                                    cbmw_pkg::FIXED_BANK : prg_bank[win];
                    r.bank_valid  = 1'b1;
                end
            end
            cbmw_pkg::KIND_PPU_FETCH: begin
                pa = addr[13:0];
                if (!pa[13]) begin
                    slot = pa[12:10];
                    if (!slot[2])
                        r.bank_number = {chr_bank[{2'b00, slot[1]}][7:1], slot[0]};
                    else
                        r.bank_number = chr_bank[slot - 3'd2];
                    r.bank_valid = 1'b1;
                end else begin
                    tbl = pa[11:10];
                    if (board_variant_q)
                        r.nametable_page = chr_bank[{2'b00, tbl[1]}][7];
                    else if (mirror_vertical)
                        r.nametable_page = tbl[0];
                    else
                        r.nametable_page = tbl[1];
                    r.page_valid = 1'b1;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic mirror_reset();
        board_variant_q = 1'b0;
        mirror_vertical = 1'b0;
        foreach (prg_bank[k]) prg_bank[k] = '0;
        foreach (chr_bank[k]) chr_bank[k] = '0;
        foreach (wram_mirror[k]) wram_mirror[k] = '0;
    endtask

    always @(posedge i_clk) begin
        t_access_res want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with no request pending");
            end else begin
                want = pending_results.pop_front();
                if (o_read_data !== want.read_data)
                    report_mismatch($sformatf("read_data %h, want %h",
                                              o_read_data, want.read_data));
                if (o_read_served !== want.read_served)
                    report_mismatch($sformatf("read_served %b, want %b",
                                              o_read_served, want.read_served));
                if (o_bank_number !== want.bank_number)
                    report_mismatch($sformatf("bank_number %h, want %h",
                                              o_bank_number, want.bank_number));
                if (o_bank_valid !== want.bank_valid)
                    report_mismatch($sformatf("bank_valid %b, want %b",
                                              o_bank_valid, want.bank_valid));
                if (o_nametable_page !== want.nametable_page)
                    report_mismatch($sformatf("nametable_page %b, want %b",
                                              o_nametable_page, want.nametable_page));
                if (o_page_valid !== want.page_valid)
                    report_mismatch($sformatf("page_valid %b, want %b",
                                              o_page_valid, want.page_valid));
            end
        end
    end

    // drives one request, waits for it to be taken, then maybe idles
    task automatic put_access(input cbmw_pkg::t_kind kind, input logic [15:0] addr,
                              input logic [7:0] wdata, input bit typed,
                              input t_access_res want);
        t_access_res got;
        i_valid      <= 1'b1;
        i_kind       <= kind;
        i_address    <= addr;
        i_write_data <= wdata;
        do @(posedge i_clk); while (!o_ready);
        got = map_access(kind, addr, wdata);
        pending_results.push_back(typed ? want : got);
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
    endtask

    task automatic put_random_access();
        int              sel;
        cbmw_pkg::t_kind kind;
        logic [15:0]     addr;
        sel  = $urandom_range(99);
        addr = 16'($urandom_range(16'hFFFF));
        if (sel < 20) begin
            kind = cbmw_pkg::KIND_CPU_WRITE;
            addr = {cbmw_pkg::REG_PAGE_HI, 4'($urandom_range(15))};
        end else if (sel < 32) begin
            kind = cbmw_pkg::KIND_CPU_WRITE;
            addr = {cbmw_pkg::WRAM_PAGE_HI, addr[7:0]};
        end else if (sel < 46) begin
            kind = cbmw_pkg::KIND_CPU_READ;
            addr = {cbmw_pkg::WRAM_PAGE_HI, addr[7:0]};
        end else if (sel < 60) begin
            kind = cbmw_pkg::KIND_CPU_READ;
            addr[15] = 1'b1;
        end else if (sel < 85) begin
            kind = cbmw_pkg::KIND_PPU_FETCH;
        end else if (sel < 92) begin
            kind = cbmw_pkg::KIND_UNUSED;
        end else begin
            kind = cbmw_pkg::t_kind'($urandom_range(2));
        end
        put_access(kind, addr, 8'($urandom_range(255)), 1'b0, RES_ALL_ZERO);
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic check_config();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_BOARD_VARIANT;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== {31'b0, board_variant_q})
            report_mismatch($sformatf("board_variant reads %h, want %0d",
                                      prdata, board_variant_q));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_config(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_BOARD_VARIANT)
            board_variant_q = data[0];
        @(posedge i_clk);
        check_config();
    endtask

    function automatic t_stim_row mk_row(cbmw_pkg::t_kind kind, logic [15:0] addr,
                                         logic [7:0] data, bit typed, t_access_res want);
        t_stim_row row;
        row.kind  = kind;
        row.addr  = addr;
        row.data  = data;
        row.typed = typed;
        row.want  = want;
        return row;
    endfunction

    initial begin
        t_stim_row row;
        logic      variant;
        int        mode;

        mirror_reset();
        // after reset: work RAM reads zero, banks zero, last window fixed
        directed_rows.push_back(mk_row(cbmw_pkg::KIND_CPU_READ,  16'h7F00, 8'h00, 1'b1,
                                       {8'h00, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0}));
        directed_rows.push_back(mk_row(cbmw_pkg::KIND_CPU_READ,  16'hE000, 8'hFF, 1'b1,
                                       {8'h00, 1'b0, cbmw_pkg::FIXED_BANK, 1'b1, 1'b0, 1'b0}));
        directed_rows.push_back(mk_row(cbmw_pkg::KIND_CPU_READ,  16'h8000, 8'h00, 1'b1,
                                       {8'h00, 1'b0, 8'h00, 1'b1, 1'b0, 1'b0}));
        directed_rows.push_back(mk_row(cbmw_pkg::KIND_PPU_FETCH, 16'h2000, 8'h00, 1'b1,
                                       {8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 1'b1}));
        directed_rows.push_back(mk_row(cbmw_pkg::KIND_CPU_WRITE, 16'h7EF0, 8'hFF, 1'b1,
                                       RES_ALL_ZERO));
        directed_rows.push_back(mk_row(cbmw_pkg::KIND_CPU_WRITE, 16'h7EF1, 8'h80, 1'b1,
                                       RES_ALL_ZERO));
        directed_rows.push_back(mk_row(cbmw_pkg::KIND_CPU_WRITE, 16'h7EF2, 8'h12, 1'b0,
                                       RES_ALL_ZERO));
        directed_rows.push_back(mk_row(cbmw_pkg::KIND_CPU_WRITE, 16'h7EF5, 8'h55, 1'b0,
                                       RES_ALL_ZERO));
        directed_rows.push_back(mk_row(cbmw_pkg::KIND_CPU_WRITE, 16'h7EF6, 8'h01, 1'b0,
                                       RES_ALL_ZERO));
        directed_rows.push_back(mk_row(cbmw_pkg::KIND_CPU_WRITE, 16'h7EFA, 8'h01, 1'b0,
                                       RES_ALL_ZERO));
        directed_rows.push_back(mk_row(cbmw_pkg::KIND_CPU_WRITE, 16'h7EFD, 8'h7F, 1'b0,
                                       RES_ALL_ZERO));
        directed_rows.push_back(mk_row(cbmw_pkg::KIND_CPU_WRITE, 16'h7EFF, 8'hFE, 1'b0,
                                       RES_ALL_ZERO));
        // hole in the register page
        directed_rows.push_back(mk_row(cbmw_pkg::KIND_CPU_WRITE, 16'h7EF8, 8'hFF, 1'b1,
                                       RES_ALL_ZERO));
        directed_rows.push_back(mk_row(cbmw_pkg::KIND_CPU_WRITE, 16'h7F00, 8'h5A, 1'b0,
                                       RES_ALL_ZERO));
        directed_rows.push_back(mk_row(cbmw_pkg::KIND_CPU_WRITE, 16'h7FFF, 8'hA5, 1'b0,
                                       RES_ALL_ZERO));
        directed_rows.push_back(mk_row(cbmw_pkg::KIND_CPU_READ,  16'h7FFF, 8'h00, 1'b0,
                                       RES_ALL_ZERO));
        directed_rows.push_back(mk_row(cbmw_pkg::KIND_CPU_READ,  16'hA000, 8'h00, 1'b0,
                                       RES_ALL_ZERO));
        directed_rows.push_back(mk_row(cbmw_pkg::KIND_CPU_READ,  16'hDFFF, 8'h00, 1'b0,
                                       RES_ALL_ZERO));
        directed_rows.push_back(mk_row(cbmw_pkg::KIND_PPU_FETCH, 16'h0400, 8'h00, 1'b0,
                                       RES_ALL_ZERO));
        directed_rows.push_back(mk_row(cbmw_pkg::KIND_PPU_FETCH, 16'h1C00, 8'h00, 1'b0,
                                       RES_ALL_ZERO));
        directed_rows.push_back(mk_row(cbmw_pkg::KIND_PPU_FETCH, 16'h2400, 8'h00, 1'b0,
                                       RES_ALL_ZERO));
        // PPU decodes only the low 14 bits
        directed_rows.push_back(mk_row(cbmw_pkg::KIND_PPU_FETCH, 16'hFFFF, 8'h00, 1'b0,
                                       RES_ALL_ZERO));
        directed_rows.push_back(mk_row(cbmw_pkg::KIND_UNUSED,    16'h7EF0, 8'h33, 1'b1,
                                       RES_ALL_ZERO));
        directed_rows.push_back(mk_row(cbmw_pkg::KIND_CPU_READ,  16'h7EFF, 8'h00, 1'b1,
                                       RES_ALL_ZERO));
        directed_rows.push_back(mk_row(cbmw_pkg::KIND_CPU_WRITE, 16'h7EF6, 8'hFE, 1'b0,
                                       RES_ALL_ZERO));
        directed_rows.push_back(mk_row(cbmw_pkg::KIND_PPU_FETCH, 16'h2800, 8'h00, 1'b0,
                                       RES_ALL_ZERO));

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        check_config();

        foreach (directed_rows[k]) begin
            row = directed_rows[k];
            put_access(row.kind, row.addr, row.data, row.typed, row.want);
        end
        i_valid <= 1'b0;

        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_drained();
            variant = 1'(p ^ (p >> 2));
            write_config(ADDR_BOARD_VARIANT, {31'($urandom()), variant});
            if (p == 4)
                write_config(ADDR_NO_REG, 32'hFFFF_FFFF);
            mode = p % 4;
            send_idle_pct   = (mode == 1) ? PCT_HEAVY : (mode == 3) ? PCT_LIGHT : 0;
            ready_stall_pct = (mode == 2) ? PCT_HEAVY : (mode == 3) ? PCT_LIGHT : 0;
            for (int n = 0; n < PHASE_ITEMS; n++)
                put_random_access();
            i_valid <= 1'b0;
        end

        wait_drained();
        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
